// File: sv/binaural_spatializer_macros.svh
// ----------------------------------------------------------------------------
// Binaural spatializer assertion macros
// Shared concurrent assertion forms clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BINAURAL_SPATIALIZER_MACROS_SVH
`define BINAURAL_SPATIALIZER_MACROS_SVH

// same-cycle implication
`define BSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/bspat_pkg.sv
// ----------------------------------------------------------------------------
// Binaural spatializer package
// Constants, codes, lane control types and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package bspat_pkg;

	localparam int DELAY_DEPTH = 512;
	localparam int TAP_COUNT   = 256;
	localparam int SAMPLE_BITS = 24;
	localparam int DELAY_AW    = $clog2(DELAY_DEPTH);
	localparam int TAP_AW      = $clog2(TAP_COUNT);
	localparam int COEF_BITS   = 16;
	localparam int ACC_BITS    = SAMPLE_BITS + COEF_BITS + TAP_AW;

	localparam logic [1:0] MODE_PARAM = 2'd1;
	localparam logic [1:0] MODE_HRIR  = 2'd2;
	localparam logic [1:0] SIDE_LEFT  = 2'd1;
	localparam logic [1:0] SIDE_RIGHT = 2'd2;
	localparam logic       OP_TAP     = 1'b1;

	localparam logic [2:0] REG_MODE       = 3'd0;
	localparam logic [2:0] REG_ITD        = 3'd1;
	localparam logic [2:0] REG_GAIN_L     = 3'd2;
	localparam logic [2:0] REG_GAIN_R     = 3'd3;
	localparam logic [2:0] REG_ALPHA      = 3'd4;
	localparam logic [2:0] REG_SIDE       = 3'd5;
	localparam logic [2:0] REG_HRIR_DLY_L = 3'd6;
	localparam logic [2:0] REG_HRIR_DLY_R = 3'd7;

	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	typedef struct packed {
		logic                        en;
		logic [TAP_AW-1:0]           addr;
		logic signed [COEF_BITS-1:0] data;
	} tap_wr_t;

	typedef struct packed {
		logic clr;
		logic rd;
	} mac_ctl_t;

	function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
		return t[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
		input logic signed [63:0] v,
		input int unsigned sh
	);
		logic signed [63:0] t;
		t = (v + (64'sd1 <<< (sh - 1))) >>> sh;
		return sat(t);
	endfunction

endpackage

// File: sv/bspat_lane.sv
// ----------------------------------------------------------------------------
// Binaural spatializer FIR lane
// Holds one ear's tap memory and multiply-accumulates it against history.
// ----------------------------------------------------------------------------
module bspat_lane (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bspat_pkg::tap_wr_t                     tap_wr,
	input  bspat_pkg::mac_ctl_t                    ctl,
	input  logic [bspat_pkg::TAP_AW-1:0]           k,
	input  logic signed [bspat_pkg::SAMPLE_BITS-1:0] hist_s1,
	output logic signed [bspat_pkg::ACC_BITS-1:0]  acc
);

	logic signed [bspat_pkg::COEF_BITS-1:0] tap_mem [bspat_pkg::TAP_COUNT];
	logic signed [bspat_pkg::COEF_BITS-1:0] tap_s1;
	logic signed [bspat_pkg::COEF_BITS+bspat_pkg::SAMPLE_BITS-1:0] prod_s2;
	logic signed [bspat_pkg::ACC_BITS-1:0] acc_q;
	logic v_s1, v_s2;

	always_ff @(posedge clk) begin
		if (tap_wr.en) begin
			tap_mem[tap_wr.addr] <= tap_wr.data;
		end
		if (ctl.rd) begin
			tap_s1 <= tap_mem[k];
		end
		prod_s2 <= tap_s1 * hist_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= ctl.rd;
			v_s2 <= v_s1;
			if (ctl.clr) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + bspat_pkg::ACC_BITS'(prod_s2);
			end
		end
	end

	assign acc = acc_q;

endmodule

// File: sv/binaural_spatializer.sv
// ----------------------------------------------------------------------------
// Binaural spatializer top level
// Bypass, parametric ITD/ILD/shadow and two-lane HRIR FIR with delay rings.
// ----------------------------------------------------------------------------
// channel | handshake                 | payload
// in      | in_valid / in_ready       | opcode, samples, tap fields, end_of_block
// out     | out_valid / out_ready     | out_left, out_right, block_last
// cfg     | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
// Tap beats keep the block idle; bypass goes to ST_DONE, parametric to ST_P_RD.
// HRIR frames do one MAC per tap in each lane, then drain through ST_H_DR1/2.
// After reset a pass zeroes the rings, history and taps before in_ready rises.
// A finished result waits in the output register; frames stall only there.
// ----------------------------------------------------------------------------
module binaural_spatializer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic signed [23:0] left_sample,
	input  logic signed [23:0] right_sample,
	input  logic [7:0]  tap_index,
	input  logic signed [15:0] tap_left,
	input  logic signed [15:0] tap_right,
	input  logic        end_of_block,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [23:0] out_left,
	output logic signed [23:0] out_right,
	output logic        block_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SB = bspat_pkg::SAMPLE_BITS;
	localparam int DA = bspat_pkg::DELAY_AW;
	localparam int TA = bspat_pkg::TAP_AW;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_P_RD, ST_P_MUL, ST_P_SAT, ST_P_SHM, ST_P_SHA,
		ST_H_MAC, ST_H_DR1, ST_H_DR2, ST_H_FIN, ST_H_RD, ST_H_OUT, ST_DONE
	} state_t;

	state_t state_q;

	logic [1:0]  mode_q, side_q;
	logic signed [9:0] itd_q;
	logic [15:0] gain_l_q, gain_r_q, alpha_q;
	logic [8:0]  hdly_l_q, hdly_r_q;

	logic signed [SB-1:0] left_ring [bspat_pkg::DELAY_DEPTH];
	logic signed [SB-1:0] right_ring [bspat_pkg::DELAY_DEPTH];
	logic signed [SB-1:0] hist_mem [bspat_pkg::TAP_COUNT];

	logic [DA-1:0] clr_cnt_q, wp_q;
	logic [TA-1:0] hwp_q, k_q;
	logic signed [SB-1:0] rd_l_q, rd_r_q, hist_s1;
	logic signed [SB-1:0] res_l_q, res_r_q, lev_l_q, lev_r_q;
	logic signed [SB+16:0] gprod_l_q, gprod_r_q;
	logic signed [SB+17:0] sprod_q;
	logic last_q, out_valid_q;
	logic signed [SB-1:0] out_l_q, out_r_q;
	logic out_last_q;

	logic cfg_we, accept, acc_frame, out_load;
	logic [DA-1:0] dl, dr, ring_wa, rd_addr_l, rd_addr_r;
	logic ring_we;
	logic signed [SB-1:0] ring_wd_l, ring_wd_r, hist_wd, fir_l, fir_r, shad_x, shad_lev;
	logic hist_we;
	logic [TA-1:0] hist_wa;
	logic [9:0] itd_mag, itd_cl;
	logic signed [SB:0] mono, diff;
	logic signed [SB-1:0] new_lev;
	bspat_pkg::tap_wr_t wr_l, wr_r;
	bspat_pkg::mac_ctl_t ctl;
	logic signed [bspat_pkg::ACC_BITS-1:0] acc_l, acc_r;
	logic shadow_on;

	assign pready   = 1'b1;
	assign cfg_we   = psel && penable && pwrite && pready;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign acc_frame = accept && (opcode != bspat_pkg::OP_TAP);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		case (paddr[4:2])
			bspat_pkg::REG_MODE:       prdata = {30'd0, mode_q};
			bspat_pkg::REG_ITD:        prdata = {{22{itd_q[9]}}, itd_q};
			bspat_pkg::REG_GAIN_L:     prdata = {16'd0, gain_l_q};
			bspat_pkg::REG_GAIN_R:     prdata = {16'd0, gain_r_q};
			bspat_pkg::REG_ALPHA:      prdata = {16'd0, alpha_q};
			bspat_pkg::REG_SIDE:       prdata = {30'd0, side_q};
			bspat_pkg::REG_HRIR_DLY_L: prdata = {23'd0, hdly_l_q};
			bspat_pkg::REG_HRIR_DLY_R: prdata = {23'd0, hdly_r_q};
			default:                   prdata = 32'd0;
		endcase
	end

	always_comb begin
		itd_mag = itd_q[9] ? 10'(-itd_q) : 10'(itd_q);
		itd_cl  = (itd_mag > 10'(bspat_pkg::DELAY_DEPTH - 1)) ?
			10'(bspat_pkg::DELAY_DEPTH - 1) : itd_mag;
		dl = '0;
		dr = '0;
		if (mode_q == bspat_pkg::MODE_HRIR) begin
			dl = (int'(hdly_l_q) > bspat_pkg::DELAY_DEPTH - 1) ?
				DA'(bspat_pkg::DELAY_DEPTH - 1) : DA'(hdly_l_q);
			dr = (int'(hdly_r_q) > bspat_pkg::DELAY_DEPTH - 1) ?
				DA'(bspat_pkg::DELAY_DEPTH - 1) : DA'(hdly_r_q);
		end else if (!itd_q[9]) begin
			dl = DA'(itd_cl);
		end else begin
			dr = DA'(itd_cl);
		end
		rd_addr_l = wp_q - dl;
		rd_addr_r = wp_q - dr;
	end

	assign fir_l = bspat_pkg::round_sat(64'(acc_l), 15);
	assign fir_r = bspat_pkg::round_sat(64'(acc_r), 15);
	assign mono  = (SB+1)'((SB+1)'(left_sample) + (SB+1)'(right_sample)) >>> 1;

	always_comb begin
		ring_we   = 1'b0;
		ring_wa   = wp_q;
		ring_wd_l = left_sample;
		ring_wd_r = right_sample;
		hist_we   = 1'b0;
		hist_wa   = hwp_q;
		hist_wd   = mono[SB-1:0];
		wr_l      = '{en: 1'b0, addr: tap_index, data: tap_left};
		wr_r      = '{en: 1'b0, addr: tap_index, data: tap_right};
		if (state_q == ST_CLEAR) begin
			ring_we   = 1'b1;
			ring_wa   = clr_cnt_q;
			ring_wd_l = '0;
			ring_wd_r = '0;
			hist_we   = 1'b1;
			hist_wa   = clr_cnt_q[TA-1:0];
			hist_wd   = '0;
			wr_l      = '{en: 1'b1, addr: clr_cnt_q[TA-1:0], data: '0};
			wr_r      = '{en: 1'b1, addr: clr_cnt_q[TA-1:0], data: '0};
		end else if (accept && opcode == bspat_pkg::OP_TAP) begin
			wr_l.en = 1'b1;
			wr_r.en = 1'b1;
		end else if (acc_frame && mode_q == bspat_pkg::MODE_PARAM) begin
			ring_we = 1'b1;
		end else if (acc_frame && mode_q == bspat_pkg::MODE_HRIR) begin
			hist_we = 1'b1;
		end else if (state_q == ST_H_FIN) begin
			ring_we   = 1'b1;
			ring_wd_l = fir_l;
			ring_wd_r = fir_r;
		end
	end

	assign ctl.rd  = (state_q == ST_H_MAC);
	assign ctl.clr = acc_frame && (mode_q == bspat_pkg::MODE_HRIR);

	always_ff @(posedge clk) begin
		if (ring_we) begin
			left_ring[ring_wa]  <= ring_wd_l;
			right_ring[ring_wa] <= ring_wd_r;
		end
		rd_l_q <= left_ring[rd_addr_l];
		rd_r_q <= right_ring[rd_addr_r];
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		if (ctl.rd) begin
			hist_s1 <= hist_mem[hwp_q - k_q];
		end
	end

	bspat_lane u_lane_l (
		.clk(clk), .arst_n(arst_n), .tap_wr(wr_l), .ctl(ctl), .k(k_q),
		.hist_s1(hist_s1), .acc(acc_l)
	);

	bspat_lane u_lane_r (
		.clk(clk), .arst_n(arst_n), .tap_wr(wr_r), .ctl(ctl), .k(k_q),
		.hist_s1(hist_s1), .acc(acc_r)
	);

	assign shadow_on = (alpha_q != 16'd0) && (side_q == bspat_pkg::SIDE_LEFT ||
		side_q == bspat_pkg::SIDE_RIGHT);
	assign shad_x   = (side_q == bspat_pkg::SIDE_LEFT) ? res_l_q : res_r_q;
	assign shad_lev = (side_q == bspat_pkg::SIDE_LEFT) ? lev_l_q : lev_r_q;
	assign diff     = (SB+1)'(shad_x) - (SB+1)'(shad_lev);
	assign new_lev  = bspat_pkg::sat(64'(shad_lev) +
		((64'(sprod_q) + 64'sd32768) >>> 16));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			mode_q      <= '0;
			itd_q       <= '0;
			gain_l_q    <= 16'd4096;
			gain_r_q    <= 16'd4096;
			alpha_q     <= '0;
			side_q      <= '0;
			hdly_l_q    <= '0;
			hdly_r_q    <= '0;
			clr_cnt_q   <= '0;
			wp_q        <= '0;
			hwp_q       <= '0;
			k_q         <= '0;
			lev_l_q     <= '0;
			lev_r_q     <= '0;
			res_l_q     <= '0;
			res_r_q     <= '0;
			gprod_l_q   <= '0;
			gprod_r_q   <= '0;
			sprod_q     <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_l_q     <= '0;
			out_r_q     <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (paddr[4:2])
					bspat_pkg::REG_MODE:       mode_q   <= pwdata[1:0];
					bspat_pkg::REG_ITD:        itd_q    <= pwdata[9:0];
					bspat_pkg::REG_GAIN_L:     gain_l_q <= pwdata[15:0];
					bspat_pkg::REG_GAIN_R:     gain_r_q <= pwdata[15:0];
					bspat_pkg::REG_ALPHA:      alpha_q  <= pwdata[15:0];
					bspat_pkg::REG_SIDE:       side_q   <= pwdata[1:0];
					bspat_pkg::REG_HRIR_DLY_L: hdly_l_q <= pwdata[8:0];
					bspat_pkg::REG_HRIR_DLY_R: hdly_r_q <= pwdata[8:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == DA'(bspat_pkg::DELAY_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc_frame) begin
						res_l_q <= left_sample;
						res_r_q <= right_sample;
						last_q  <= end_of_block;
						k_q     <= '0;
						if (mode_q == bspat_pkg::MODE_PARAM) begin
							state_q <= ST_P_RD;
						end else if (mode_q == bspat_pkg::MODE_HRIR) begin
							state_q <= ST_H_MAC;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_P_RD: begin
					wp_q    <= wp_q + 1'b1;
					state_q <= ST_P_MUL;
				end
				ST_P_MUL: begin
					gprod_l_q <= rd_l_q * $signed({1'b0, gain_l_q});
					gprod_r_q <= rd_r_q * $signed({1'b0, gain_r_q});
					state_q   <= ST_P_SAT;
				end
				ST_P_SAT: begin
					res_l_q <= bspat_pkg::round_sat(64'(gprod_l_q), 12);
					res_r_q <= bspat_pkg::round_sat(64'(gprod_r_q), 12);
					state_q <= shadow_on ? ST_P_SHM : ST_DONE;
				end
				ST_P_SHM: begin
					sprod_q <= diff * $signed({1'b0, alpha_q});
					state_q <= ST_P_SHA;
				end
				ST_P_SHA: begin
					if (side_q == bspat_pkg::SIDE_LEFT) begin
						lev_l_q <= new_lev;
						res_l_q <= new_lev;
					end else begin
						lev_r_q <= new_lev;
						res_r_q <= new_lev;
					end
					state_q <= ST_DONE;
				end
				ST_H_MAC: begin
					k_q <= k_q + 1'b1;
					if (k_q == TA'(bspat_pkg::TAP_COUNT - 1)) begin
						state_q <= ST_H_DR1;
					end
				end
				ST_H_DR1: state_q <= ST_H_DR2;
				ST_H_DR2: state_q <= ST_H_FIN;
				ST_H_FIN: state_q <= ST_H_RD;
				ST_H_RD: begin
					wp_q    <= wp_q + 1'b1;
					hwp_q   <= hwp_q + 1'b1;
					state_q <= ST_H_OUT;
				end
				ST_H_OUT: begin
					res_l_q <= rd_l_q;
					res_r_q <= rd_r_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_l_q     <= res_l_q;
						out_r_q     <= res_r_q;
						out_last_q  <= last_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_left   = out_l_q;
	assign out_right  = out_r_q;
	assign block_last = out_last_q;

endmodule

// File: sv/bspat_checker.sv
// ----------------------------------------------------------------------------
// Binaural spatializer port checker
// Watches the stream ports and pready of the top level over time.
// ----------------------------------------------------------------------------
`include "binaural_spatializer_macros.svh"

module bspat_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        opcode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] out_left,
	input logic [23:0] out_right,
	input logic        block_last,
	input logic        pready
);

	`BSP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_left) && $stable(out_right) && $stable(block_last), "output beat dropped or changed while stalled")
	`BSP_ASSERT_NXT(a_frame_busy, in_valid && in_ready && !opcode, !in_ready, "frame beat did not make the block busy")
	`BSP_ASSERT_NXT(a_tap_quick, in_valid && in_ready && opcode, in_ready, "tap load beat did not complete in one cycle")
	`BSP_ASSERT_IMP(a_out_from_work, $rose(out_valid), !$past(in_ready), "result appeared without a frame in flight")
	`BSP_ASSERT_IMP(a_pready, 1'b1, pready, "config port not ready")

endmodule

bind binaural_spatializer bspat_checker u_bspat_checker (.*);
